// ===== design/tvp_pkg.sv =====
// Shared types and codes for the trapezoidal velocity profile block.
`timescale 1ns / 1ps
package tvp_pkg;

    localparam int APB_AW = 4;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_ACCEL = 2'd0;
    localparam logic [1:0] REG_SPEED = 2'd1;
    localparam logic [1:0] REG_DIST  = 2'd2;

    // Phase codes
    localparam logic [1:0] PH_ACCEL  = 2'd0;
    localparam logic [1:0] PH_CRUISE = 2'd1;
    localparam logic [1:0] PH_DECEL  = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    typedef struct packed {
        logic [31:0] accel;
        logic [31:0] speed;
        logic [31:0] distance;
    } t_cfg;

    typedef struct packed {
        logic [31:0] ta;
        logic [31:0] tc;
        logic [31:0] peak;
        logic        bad;
    } t_prof;

endpackage

// ===== design/tvp_if.sv =====
// Request and result channel interfaces.
`timescale 1ns / 1ps
interface tvp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] elapsed_time;
    modport source (output valid, output elapsed_time, input ready);
    modport sink   (input valid, input elapsed_time, output ready);
endinterface

interface tvp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] velocity;
    logic [1:0]  phase;
    logic        bad_setting;
    modport source (output valid, output velocity, output phase, output bad_setting,
                    input ready);
    modport sink   (input valid, input velocity, input phase, input bad_setting,
                    output ready);
endinterface

// ===== design/tvp_apb.sv =====
// APB register file: acceleration, speed limit, move distance.
`timescale 1ns / 1ps
module tvp_apb #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tvp_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output tvp_pkg::t_cfg              o_cfg,
    output logic                       o_wr
);
    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

    tvp_pkg::t_cfg r_cfg;
    logic [1:0]    idx;

    assign idx    = paddr[3:2];
    assign pready = 1'b1;
    assign o_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel    <= ONE;
            r_cfg.speed    <= ONE;
            r_cfg.distance <= '0;
        end else if (o_wr) begin
            unique case (idx)
                tvp_pkg::REG_ACCEL: r_cfg.accel    <= pwdata;
                tvp_pkg::REG_SPEED: r_cfg.speed    <= pwdata;
                tvp_pkg::REG_DIST:  r_cfg.distance <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            tvp_pkg::REG_ACCEL: prdata = r_cfg.accel;
            tvp_pkg::REG_SPEED: prdata = r_cfg.speed;
            tvp_pkg::REG_DIST:  prdata = r_cfg.distance;
            default:            prdata = '0;
        endcase
    end
endmodule

// ===== design/tvp_solver.sv =====
// Sequential solver for ramp time, cruise time and peak speed (shared divider, root).
`timescale 1ns / 1ps
module tvp_solver #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tvp_pkg::t_cfg i_cfg,
    input  logic          i_wr,
    output tvp_pkg::t_prof o_prof,
    output logic          o_busy
);
    localparam int DW = (32 + 2 * FRAC_BITS > 64) ? 32 + 2 * FRAC_BITS : 64;
    localparam int CW = $clog2(DW + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_START  = 4'd1;
    localparam logic [3:0] ST_DIV    = 4'd2;
    localparam logic [3:0] ST_CMP    = 4'd3;
    localparam logic [3:0] ST_TC_LD  = 4'd4;
    localparam logic [3:0] ST_TC_END = 4'd5;
    localparam logic [3:0] ST_SQ_LD  = 4'd6;
    localparam logic [3:0] ST_SQRT   = 4'd7;
    localparam logic [3:0] ST_PEAK   = 4'd8;
    localparam logic [3:0] ST_PEAK2  = 4'd9;

    logic [3:0]    r_state, r_after;
    logic [DW-1:0] r_num;
    logic [31:0]   r_den, r_rem, r_diff;
    logic [CW-1:0] r_cnt;
    logic [63:0]   r_x, r_res, r_bit, r_prod;
    logic [31:0]   r_ta, r_tc, r_peak;
    logic          r_bad;

    logic [32:0]   rem_sh;
    logic          q_bit;
    logic [31:0]   rem_nx;
    logic [63:0]   trial, prod_sh;
    logic          take;
    logic [31:0]   num_sat, peak_sat;

    assign rem_sh   = {r_rem, r_num[DW-1]};
    assign q_bit    = rem_sh >= {1'b0, r_den};
    assign rem_nx   = q_bit ? 32'(rem_sh - {1'b0, r_den}) : rem_sh[31:0];
    assign trial    = r_res + r_bit;
    assign take     = r_x >= trial;
    assign num_sat  = ((r_num >> 32) != '0) ? 32'hFFFF_FFFF : r_num[31:0];
    assign prod_sh  = r_prod >> FRAC_BITS;
    assign peak_sat = ((prod_sh >> 32) != '0) ? 32'hFFFF_FFFF : prod_sh[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
            r_bad   <= 1'b0;
        end else if (i_wr) begin
            r_state <= ST_START;
        end else begin
            unique case (r_state)
                ST_IDLE: ;
                ST_START: begin
                    r_bad <= (i_cfg.accel == '0) || (i_cfg.speed == '0);
                    if ((i_cfg.accel == '0) || (i_cfg.speed == '0)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_num   <= DW'(64'(i_cfg.speed) * 64'(i_cfg.speed));
                        r_den   <= i_cfg.accel;
                        r_rem   <= '0;
                        r_cnt   <= CW'(DW);
                        r_after <= ST_CMP;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_cnt != '0) begin
                        r_num <= {r_num[DW-2:0], q_bit};
                        r_rem <= rem_nx;
                        r_cnt <= r_cnt - CW'(1);
                    end else begin
                        r_state <= r_after;
                    end
                end
                ST_CMP: begin
                    r_rem <= '0;
                    r_cnt <= CW'(DW);
                    r_den <= i_cfg.accel;
                    r_state <= ST_DIV;
                    if (r_num < DW'(i_cfg.distance)) begin
                        r_diff  <= i_cfg.distance - r_num[31:0];
                        r_num   <= DW'(i_cfg.speed) << FRAC_BITS;
                        r_after <= ST_TC_LD;
                    end else begin
                        r_num   <= DW'(i_cfg.distance) << (2 * FRAC_BITS);
                        r_after <= ST_SQ_LD;
                    end
                end
                ST_TC_LD: begin
                    r_ta    <= num_sat;
                    r_peak  <= i_cfg.speed;
                    r_num   <= DW'(r_diff) << FRAC_BITS;
                    r_den   <= i_cfg.speed;
                    r_rem   <= '0;
                    r_cnt   <= CW'(DW);
                    r_after <= ST_TC_END;
                    r_state <= ST_DIV;
                end
                ST_TC_END: begin
                    r_tc    <= num_sat;
                    r_state <= ST_IDLE;
                end
                ST_SQ_LD: begin
                    r_tc <= '0;
                    if ((r_num >> 64) != '0) begin
                        r_ta    <= 32'hFFFF_FFFF;
                        r_state <= ST_PEAK;
                    end else begin
                        r_x     <= r_num[63:0];
                        r_res   <= '0;
                        r_bit   <= 64'(1) << 62;
                        r_cnt   <= CW'(32);
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (r_cnt != '0) begin
                        if (take) begin
                            r_x   <= r_x - trial;
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                        r_cnt <= r_cnt - CW'(1);
                    end else begin
                        r_ta    <= r_res[31:0];
                        r_state <= ST_PEAK;
                    end
                end
                ST_PEAK: begin
                    r_prod  <= 64'(i_cfg.accel) * 64'(r_ta);
                    r_state <= ST_PEAK2;
                end
                ST_PEAK2: begin
                    r_peak  <= peak_sat;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_busy      = r_state != ST_IDLE;
    assign o_prof.ta   = r_ta;
    assign o_prof.tc   = r_tc;
    assign o_prof.peak = r_peak;
    assign o_prof.bad  = r_bad;
endmodule

// ===== design/tvp_pipe.sv =====
// Four-register evaluation pipeline: capture, phase select, multiply, shape.
`timescale 1ns / 1ps
module tvp_pipe #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_busy,
    input  logic [31:0]    i_accel,
    input  tvp_pkg::t_prof i_prof,
    tvp_in_if.sink         i_req,
    tvp_out_if.source      o_res
);
    logic        r_a_v, r_b_v, r_c_v, r_d_v;
    logic [31:0] r_a_t;
    logic [31:0] r_b_m;
    logic [1:0]  r_b_ph, r_c_ph, r_d_ph;
    logic        r_b_bad, r_c_bad, r_d_bad;
    logic [63:0] r_c_prod;
    logic [31:0] r_d_vel;

    logic        en_a, en_b, en_c, en_d;
    logic [32:0] sum_c;
    logic [33:0] stop;
    logic [1:0]  n_ph;
    logic [31:0] n_m;
    logic [63:0] drop;
    logic [31:0] n_vel;

    assign en_d = !r_d_v || o_res.ready;
    assign en_c = !r_c_v || en_d;
    assign en_b = !r_b_v || en_c;
    assign en_a = !r_a_v || en_b;
    assign i_req.ready = en_a && !i_busy;

    // phase from time compares
    assign sum_c = {1'b0, i_prof.ta} + {1'b0, i_prof.tc};
    assign stop  = {1'b0, sum_c} + {2'b0, i_prof.ta};

    always_comb begin
        if (i_prof.bad) begin
            n_ph = tvp_pkg::PH_DONE;
        end else if (r_a_t <= i_prof.ta) begin
            n_ph = tvp_pkg::PH_ACCEL;
        end else if ({1'b0, r_a_t} <= sum_c) begin
            n_ph = tvp_pkg::PH_CRUISE;
        end else if ({2'b0, r_a_t} < stop) begin
            n_ph = tvp_pkg::PH_DECEL;
        end else begin
            n_ph = tvp_pkg::PH_DONE;
        end
        n_m = (n_ph == tvp_pkg::PH_ACCEL) ? r_a_t : r_a_t - sum_c[31:0];
    end

    assign drop = r_c_prod >> FRAC_BITS;

    always_comb begin
        case (r_c_ph)
            tvp_pkg::PH_ACCEL:  n_vel = ((drop >> 32) != '0) ? 32'hFFFF_FFFF : drop[31:0];
            tvp_pkg::PH_CRUISE: n_vel = i_prof.peak;
            tvp_pkg::PH_DECEL:  n_vel = (drop >= 64'(i_prof.peak)) ? 32'd0
                                                                  : i_prof.peak - drop[31:0];
            default:            n_vel = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            if (en_a) r_a_v <= i_req.valid && i_req.ready;
            if (en_b) r_b_v <= r_a_v;
            if (en_c) r_c_v <= r_b_v;
            if (en_d) r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_t <= i_req.elapsed_time;
        end
        if (en_b) begin
            r_b_m   <= n_m;
            r_b_ph  <= n_ph;
            r_b_bad <= i_prof.bad;
        end
        if (en_c) begin
            r_c_prod <= 64'(i_accel) * 64'(r_b_m);
            r_c_ph   <= r_b_ph;
            r_c_bad  <= r_b_bad;
        end
        if (en_d) begin
            r_d_vel <= n_vel;
            r_d_ph  <= r_c_ph;
            r_d_bad <= r_c_bad;
        end
    end

    assign o_res.valid       = r_d_v;
    assign o_res.velocity    = r_d_vel;
    assign o_res.phase       = r_d_ph;
    assign o_res.bad_setting = r_d_bad;
endmodule

// ===== design/trapezoidal_velocity_profile.sv =====
// Top level of the trapezoidal velocity profile evaluator.
//
//   channel   direction  handshake       payload
//   i_req     in         valid / ready   elapsed_time[31:0]
//   o_res     out        valid / ready   velocity[31:0], phase[1:0], bad_setting
//   APB       in / out   psel / penable  paddr[3:0], pwdata, prdata (pready tied high)
//
// One request per cycle, while the solver is idle and the pipeline has room, enters the
// four-register pipeline; each result passes the capture, phase select, multiply and
// shape registers in turn. The profile constants (ramp time, cruise time, peak) come
// from a shared bit-serial divider and square root that run after reset and after
// every register write, during which i_req.ready stays low.
// Reset is synchronous and active low. A stalled o_res freezes only the stages
// that hold data; empty stages keep filling, so nothing is dropped or repeated.
`timescale 1ns / 1ps
module trapezoidal_velocity_profile #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tvp_in_if.sink                     i_req,
    tvp_out_if.source                  o_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tvp_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    tvp_pkg::t_cfg  cfg;
    tvp_pkg::t_prof prof;
    logic           cfg_wr;
    logic           busy;

    // hold the three move registers
    tvp_apb #(.FRAC_BITS(FRAC_BITS)) u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg),
        .o_wr    (cfg_wr)
    );

    // derive ta, tc and peak from the registers
    tvp_solver #(.FRAC_BITS(FRAC_BITS)) u_solver (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_wr    (cfg_wr),
        .o_prof  (prof),
        .o_busy  (busy)
    );

    // evaluate one elapsed time per cycle while the solver is idle and the pipeline has room
    tvp_pipe #(.FRAC_BITS(FRAC_BITS)) u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_busy  (busy),
        .i_accel (cfg.accel),
        .i_prof  (prof),
        .i_req   (i_req),
        .o_res   (o_res)
    );

    // a register write must block new requests until the solver finishes
    a_wr_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> !i_req.ready)
        else $error("request path open right after a register write");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.bad_setting) |->
            (o_res.phase == tvp_pkg::PH_DONE && o_res.velocity == 32'd0))
        else $error("bad setting without zero velocity");

    a_cruise_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.phase == tvp_pkg::PH_CRUISE) |->
            (o_res.velocity == prof.peak))
        else $error("cruise velocity differs from peak");

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.phase == tvp_pkg::PH_DONE) |-> (o_res.velocity == 32'd0))
        else $error("nonzero velocity after stop");
endmodule
